### rtl/fnb_pkg.sv
// Shared constants, types and the segment table of the number frame builder.
// No dependencies; every other file of the block but fnb_if imports this package.
`default_nettype none

package fnb_pkg;

  // Default number of decimal digits taken from the input number (1 to 10)
  localparam int MAX_DIGITS_DEF = 8;

  // Driver command and address bytes
  localparam logic [7:0] CMD_AUTO_INC = 8'h40;
  localparam logic [7:0] ADDR_BASE    = 8'hC0;
  localparam logic [7:0] POINT_BIT    = 8'h80;

  // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP_10    = 32'hCCCCCCCD;
  localparam int          RECIP_SHIFT = 35;

  // Request data that travels beside the digits
  typedef struct packed {
    logic [7:0] addr;   // finished address byte
    logic [3:0] count;  // clamped digit count
    logic       point;  // decimal point on the last digit
  } fnb_req_t;

  // Common-cathode segment code of one decimal digit
  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/fnb_if.sv
// Valid/ready channel interfaces for display requests and output bytes.
// No dependencies.
`default_nettype none

interface fnb_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [4:0]  first_grid;
  logic [3:0]  num_digits;
  logic        show_point;

  modport source (output valid, value, first_grid, num_digits, show_point,
                  input ready);
  modport sink   (input valid, value, first_grid, num_digits, show_point,
                  output ready);
endinterface

interface fnb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;
  logic       frame_end;
  logic       last;

  modport source (output valid, data_byte, frame_start, frame_end, last,
                  input ready);
  modport sink   (input valid, data_byte, frame_start, frame_end, last,
                  output ready);
endinterface

`default_nettype wire

### rtl/fnb_digit_pipe.sv
// Input register and one pipeline stage per decimal digit.
// Depends on fnb_pkg and fnb_in_if.
`default_nettype none

module fnb_digit_pipe #(
  parameter int MAX_DIGITS = fnb_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  fnb_in_if.sink                           request,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output fnb_pkg::fnb_req_t                out_req,
  output logic [MAX_DIGITS-1:0][3:0]       out_digits
);
  import fnb_pkg::*;

  // Stage 0 is the input register, stage k+1 holds digits 0..k
  logic                        vld    [0:MAX_DIGITS];
  logic [31:0]                 rest   [0:MAX_DIGITS];
  fnb_req_t                    req    [0:MAX_DIGITS];
  logic [MAX_DIGITS-1:0][3:0]  dig    [0:MAX_DIGITS];
  logic                        adv;
  logic [3:0]                  cnt_clamp;

  // Whole pipe moves whenever the last stage is empty or being taken
  assign adv           = !vld[MAX_DIGITS] || out_ready;
  assign request.ready = adv;

  assign cnt_clamp = (request.num_digits > 4'(MAX_DIGITS)) ?
                     4'(MAX_DIGITS) : request.num_digits;

  // Input stage: clamp count, form the address byte
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rest[0]      <= request.value;
      req[0].addr  <= ADDR_BASE + {3'b000, request.first_grid} - 8'd1;
      req[0].count <= cnt_clamp;
      req[0].point <= request.show_point;
      dig[0]       <= '0;
    end
  end

  // Digit stages: divide by ten through the reciprocal, keep the remainder
  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_digit
    logic [63:0] prod;
    logic [28:0] quo;
    logic [3:0]  quo10;
    logic [3:0]  rem;
    logic [MAX_DIGITS-1:0][3:0] dig_next;

    assign prod  = 64'(rest[k]) * 64'(RECIP_10);
    assign quo   = prod[63:RECIP_SHIFT];
    // only the low nibble of 10*q is needed, the remainder is below ten
    assign quo10 = {quo[0], 3'b000} + {quo[2:0], 1'b0};
    assign rem   = rest[k][3:0] - quo10;

    // digits so far plus the one found here
    always_comb begin
      dig_next    = dig[k];
      dig_next[k] = rem;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rest[k+1] <= {3'b000, quo};
        req[k+1]  <= req[k];
        dig[k+1]  <= dig_next;
      end
    end
  end

  assign out_valid  = vld[MAX_DIGITS];
  assign out_req    = req[MAX_DIGITS];
  assign out_digits = dig[MAX_DIGITS];

endmodule

`default_nettype wire

### rtl/seven_segment_number_frame_builder.sv
// Top level: digit pipeline feeding the byte serializer of the two frames.
// Depends on fnb_pkg, fnb_if and fnb_digit_pipe.
`default_nettype none

// Takes one display request per transfer and emits the driver's byte stream:
// the auto-increment command 0x40 as its own frame, then the address byte and
// the segment codes, most significant digit first. The decimal digits come out
// of a pipeline of MAX_DIGITS+1 register stages, one constant-reciprocal
// multiplier per digit, and a request reaches the serializer once it has
// passed every stage. The serializer sends one byte per cycle while the output
// is ready, a request giving 2 + min(digit count, MAX_DIGITS) bytes; the next
// request is loaded in the same cycle as the final byte of the previous one,
// and the input accepts a request every cycle while the pipeline moves.
module seven_segment_number_frame_builder #(
  parameter int MAX_DIGITS = fnb_pkg::MAX_DIGITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  fnb_in_if.sink    request,
  fnb_out_if.source frame
);
  import fnb_pkg::*;

  localparam int DSW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam logic [1:0] PH_CMD  = 2'd0;
  localparam logic [1:0] PH_ADDR = 2'd1;
  localparam logic [1:0] PH_DIG  = 2'd2;

  logic                        pipe_valid;
  logic                        pipe_ready;
  fnb_req_t                    pipe_req;
  logic [MAX_DIGITS-1:0][3:0]  pipe_digits;

  logic                        busy;
  logic [1:0]                  phase;
  logic [DSW-1:0]              dsel;
  fnb_req_t                    s_req;
  logic [MAX_DIGITS-1:0][3:0]  s_dig;

  logic                        xfer;
  logic                        done;
  logic                        load;
  logic                        dig_final;
  logic [7:0]                  byte_out;
  logic                        fs_out;
  logic                        fe_out;
  logic                        last_out;

  fnb_digit_pipe #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_pipe (
    .clk        (clk),
    .rst        (rst),
    .request    (request),
    .out_valid  (pipe_valid),
    .out_ready  (pipe_ready),
    .out_req    (pipe_req),
    .out_digits (pipe_digits)
  );

  // Handshake between pipe and serializer
  assign xfer       = busy && frame.ready;
  assign done       = xfer && last_out;
  assign pipe_ready = !busy || done;
  assign load       = pipe_valid && pipe_ready;

  // Serializer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= PH_CMD;
    end else if (load) begin
      busy  <= 1'b1;
      phase <= PH_CMD;
    end else if (done) begin
      busy  <= 1'b0;
    end else if (xfer) begin
      unique case (phase)
        PH_CMD:  phase <= PH_ADDR;
        PH_ADDR: phase <= PH_DIG;
        PH_DIG:  phase <= PH_DIG;
        default: phase <= PH_CMD;
      endcase
    end
  end

  // Request data and digit pointer
  always_ff @(posedge clk) begin
    if (load) begin
      s_req <= pipe_req;
      s_dig <= pipe_digits;
      dsel  <= DSW'(pipe_req.count - 4'd1);
    end else if (xfer && phase == PH_DIG) begin
      dsel  <= dsel - DSW'(1);
    end
  end

  // Byte selection
  assign dig_final = (dsel == '0);

  always_comb begin
    unique case (phase)
      PH_CMD: begin
        byte_out = CMD_AUTO_INC;
        fs_out   = 1'b1;
        fe_out   = 1'b1;
        last_out = 1'b0;
      end
      PH_ADDR: begin
        byte_out = s_req.addr;
        fs_out   = 1'b1;
        fe_out   = (s_req.count == 4'd0);
        last_out = (s_req.count == 4'd0);
      end
      PH_DIG: begin
        byte_out = seg_code(s_dig[dsel]) |
                   ((dig_final && s_req.point) ? POINT_BIT : 8'h00);
        fs_out   = 1'b0;
        fe_out   = dig_final;
        last_out = dig_final;
      end
      default: begin
        byte_out = 8'h00;
        fs_out   = 1'b0;
        fe_out   = 1'b0;
        last_out = 1'b0;
      end
    endcase
  end

  assign frame.valid       = busy;
  assign frame.data_byte   = byte_out;
  assign frame.frame_start = fs_out;
  assign frame.frame_end   = fe_out;
  assign frame.last        = last_out;

endmodule

`default_nettype wire

### rtl/fnb_checker.sv
// Port-level checks of the frame byte stream, bound to the top level.
// Depends on fnb_pkg and seven_segment_number_frame_builder.
`default_nettype none

module fnb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       frm_valid,
  input wire logic       frm_ready,
  input wire logic [7:0] data_byte,
  input wire logic       frame_start,
  input wire logic       frame_end,
  input wire logic       last
);
  import fnb_pkg::*;

  logic xfer;
  logic expect_cmd;  // next byte opens a new request
  logic after_cmd;   // next byte is the address byte

  assign xfer = frm_valid && frm_ready;

  // Track position within a request's byte sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_cmd <= 1'b1;
      after_cmd  <= 1'b0;
    end else if (xfer) begin
      expect_cmd <= last;
      after_cmd  <= expect_cmd;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    frm_valid && !frm_ready |=> frm_valid && $stable(data_byte) &&
      $stable(frame_start) && $stable(frame_end) && $stable(last))
    else $error("output byte changed while stalled");

  a_cmd_first: assert property (@(posedge clk) disable iff (rst)
    frm_valid && expect_cmd |-> data_byte == CMD_AUTO_INC && frame_start &&
      frame_end && !last)
    else $error("request does not open with the command frame");

  a_addr_second: assert property (@(posedge clk) disable iff (rst)
    frm_valid && after_cmd |-> frame_start && (frame_end == last))
    else $error("address byte does not open the second frame");

  a_seg_body: assert property (@(posedge clk) disable iff (rst)
    frm_valid && !expect_cmd && !after_cmd |-> !frame_start &&
      (frame_end == last))
    else $error("segment byte framing is wrong");

endmodule

bind seven_segment_number_frame_builder fnb_checker u_fnb_checker (
  .clk         (clk),
  .rst         (rst),
  .frm_valid   (frame.valid),
  .frm_ready   (frame.ready),
  .data_byte   (frame.data_byte),
  .frame_start (frame.frame_start),
  .frame_end   (frame.frame_end),
  .last        (frame.last)
);

`default_nettype wire

### verif/fnb_frame_checker.sv
`timescale 1ns / 100ps
// Checker for the number frame builder: watches both channels, predicts the byte stream.
// Depends on fnb_pkg and the fnb_in_if / fnb_out_if interfaces.

module fnb_frame_checker (
  input  logic clk,
  input  logic rst,
  fnb_in_if    req,
  fnb_out_if   frm,
  output int   mismatch_count,
  output int   bytes_pending
);
  import fnb_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
    logic       frame_end;
    logic       last;
  } frame_byte_t;

  localparam int DIGITS = MAX_DIGITS_DEF;

  // Common-cathode codes, digit 0 to 9
  localparam logic [7:0] SEG_LUT [10] = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66,
                                          8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f};

  frame_byte_t expected_bytes[$];
  frame_byte_t got_byte;
  frame_byte_t want_byte;

  initial begin
    mismatch_count = 0;
    bytes_pending  = 0;
  end

  // Queue up every byte one display request produces
  function automatic void queue_display_bytes(input logic [31:0] number,
                                              input logic [4:0]  grid,
                                              input logic [3:0]  ndig,
                                              input logic        dp);
    logic [3:0]  dec [DIGITS];
    logic [31:0] rest;
    int          cnt;
    frame_byte_t b;
    rest = number;
    for (int i = 0; i < DIGITS; i++) begin
      dec[i] = 4'(rest % 32'd10);
      rest   = rest / 32'd10;
    end
    cnt = (int'(ndig) > DIGITS) ? DIGITS : int'(ndig);
    // data command frame
    b = '{CMD_AUTO_INC, 1'b1, 1'b1, 1'b0};
    expected_bytes.push_back(b);
    // address byte opens the second frame, closes it when no digits follow
    b = '{8'(ADDR_BASE + {3'b000, grid} - 8'd1), 1'b1, cnt == 0, cnt == 0};
    expected_bytes.push_back(b);
    // segment codes, most significant digit first
    for (int i = 0; i < cnt; i++) begin
      b.data_byte   = SEG_LUT[dec[cnt - 1 - i]];
      b.frame_start = 1'b0;
      b.frame_end   = (i == cnt - 1);
      b.last        = (i == cnt - 1);
      if (i == cnt - 1 && dp) b.data_byte = b.data_byte | POINT_BIT;
      expected_bytes.push_back(b);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      // output transfer: compare against the oldest expected byte
      if (frm.valid && frm.ready) begin
        got_byte = '{frm.data_byte, frm.frame_start, frm.frame_end, frm.last};
        if (expected_bytes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected byte %h fs=%b fe=%b last=%b", $time,
                     got_byte.data_byte, got_byte.frame_start, got_byte.frame_end,
                     got_byte.last);
        end else begin
          want_byte = expected_bytes.pop_front();
          if (got_byte.data_byte !== want_byte.data_byte ||
              got_byte.frame_start !== want_byte.frame_start ||
              got_byte.frame_end !== want_byte.frame_end ||
              got_byte.last !== want_byte.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: exp %h fs=%b fe=%b last=%b, got %h fs=%b fe=%b last=%b",
                       $time, want_byte.data_byte, want_byte.frame_start,
                       want_byte.frame_end, want_byte.last, got_byte.data_byte,
                       got_byte.frame_start, got_byte.frame_end, got_byte.last);
          end
        end
      end
      // input transfer: predict its bytes
      if (req.valid && req.ready)
        queue_display_bytes(req.value, req.first_grid, req.num_digits,
                            req.show_point);
      bytes_pending = expected_bytes.size();
    end
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// Top of the number frame builder testbench: clock, reset, request stimulus, output stalls.
// Depends on fnb_pkg, fnb_if, the block itself and fnb_frame_checker.

module testbench;

  logic clk = 1'b0;
  logic rst;
  int   mismatch_count;
  int   bytes_pending;
  int   stall_left;
  bit   steady;

  fnb_in_if  req_ch ();
  fnb_out_if frm_ch ();

  seven_segment_number_frame_builder dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .frame   (frm_ch)
  );

  fnb_frame_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .frm            (frm_ch),
    .mismatch_count (mismatch_count),
    .bytes_pending  (bytes_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Mostly no gap, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Output side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      frm_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      frm_ch.ready <= 1'b1;
      if (!steady && $urandom_range(0, 99) < 25)
        stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                 : $urandom_range(8, 30);
    end
  end

  // One request transfer, then an optional idle gap
  task automatic send_display(input logic [31:0] number, input logic [4:0] grid,
                              input logic [3:0] ndig, input logic dp);
    int gap;
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.value      <= number;
    req_ch.first_grid <= grid;
    req_ch.num_digits <= ndig;
    req_ch.show_point <= dp;
    do @(posedge clk); while (!req_ch.ready);
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop sending until every predicted byte has come out
  task automatic drain_output();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (bytes_pending != 0) @(negedge clk);
  endtask

  task automatic send_random_display();
    logic [31:0] number;
    logic [4:0]  grid;
    logic [3:0]  ndig;
    case ($urandom_range(0, 3))
      0: number = $urandom;
      1: number = $urandom_range(0, 99999999);
      2: number = $urandom_range(0, 999);
      default: number = $urandom_range(0, 9) * 32'd11111111 + $urandom_range(0, 9);
    endcase
    grid = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(1, 16))
                                        : 5'($urandom_range(0, 31));
    ndig = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 8))
                                        : 4'($urandom_range(9, 15));
    send_display(number, grid, ndig, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst               = 1'b1;
    steady            = 1'b0;
    stall_left        = 0;
    req_ch.valid      = 1'b0;
    req_ch.value      = '0;
    req_ch.first_grid = '0;
    req_ch.num_digits = '0;
    req_ch.show_point = 1'b0;
    frm_ch.ready      = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes, clamping, zero digits, odd start positions
    send_display(32'd0,          5'd1,  4'd1,  1'b0);
    send_display(32'd0,          5'd1,  4'd8,  1'b1);
    send_display(32'hFFFFFFFF,   5'd16, 4'd8,  1'b1);
    send_display(32'hFFFFFFFF,   5'd16, 4'd15, 1'b0);
    send_display(32'd12345678,   5'd1,  4'd8,  1'b0);
    send_display(32'd12345678,   5'd5,  4'd3,  1'b1);
    send_display(32'd1234567890, 5'd2,  4'd8,  1'b1);
    send_display(32'd98765432,   5'd8,  4'd8,  1'b0);
    send_display(32'd100000000,  5'd3,  4'd8,  1'b1);
    send_display(32'd99999999,   5'd4,  4'd9,  1'b0);
    send_display(32'd55,         5'd1,  4'd0,  1'b1);
    send_display(32'd55,         5'd16, 4'd0,  1'b0);
    send_display(32'd7,          5'd0,  4'd1,  1'b1);
    send_display(32'd7,          5'd0,  4'd0,  1'b0);
    send_display(32'd42,         5'd31, 4'd2,  1'b0);
    send_display(32'd4096,       5'd17, 4'd4,  1'b1);
    send_display(32'd31415926,   5'd21, 4'd10, 1'b1);
    send_display(32'd27182818,   5'd10, 4'd12, 1'b0);
    send_display(32'd60606,      5'd12, 4'd5,  1'b1);
    send_display(32'h80000000,   5'd6,  4'd7,  1'b0);
    send_display(32'd9,          5'd15, 4'd6,  1'b1);
    drain_output();

    // Random: alternating stretches with and without idling
    for (int i = 0; i < 430; i++) begin
      steady = ((i / 60) % 3 == 1);
      if (i == 200) drain_output();
      send_random_display();
    end
    steady = 1'b0;
    drain_output();
    repeat (30) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
